### sv/ira_pkg.sv
// package with shared types, constants and helper functions of the radix formatter
`default_nettype none
package ira_pkg;

  localparam int unsigned RADIX_W   = 6;
  localparam int unsigned CHAR_W    = 7;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_NINE   = 7'd57;
  localparam logic [CHAR_W-1:0]  LETTER_BASE = 7'd64;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS  = 7'd45;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_LOAD
  } ira_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    c = {1'b0, d} + CHAR_ZERO;
    if (c > CHAR_NINE) c = c + (LETTER_BASE - CHAR_NINE);
    return c;
  endfunction

endpackage
`default_nettype wire

### sv/ira_if.sv
// stream interfaces for value requests, character results and radix writes
`default_nettype none
interface ira_value_if #(
  parameter int unsigned WIDTH = 32
) ();
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface ira_char_if ();
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last;
  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface ira_cfg_if ();
  logic       valid;
  logic       ready;
  logic [5:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/ira_ram.sv
// generic single write port ram with registered read
`default_nettype none
module ira_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### sv/ira_div.sv
// bit-serial restoring divider by the radix, one quotient bit per cycle
`default_nettype none
module ira_div import ira_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [VALUE_WIDTH-1:0] dividend_i,
  input  wire logic [RADIX_W-1:0]     radix_i,
  output div_stat_t                   stat_o,
  output logic      [VALUE_WIDTH-1:0] quot_o,
  output logic      [RADIX_W-1:0]     rem_o
);

  localparam int unsigned BW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [BW-1:0]          cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic [RADIX_W-1:0]     rem_q, rem_d;
  logic [RADIX_W:0]       trial;
  logic [RADIX_W:0]       diff;
  logic                   ge;

  assign trial = {rem_q, mag_q[VALUE_WIDTH-1]};
  assign ge    = trial >= {1'b0, radix_i};
  assign diff  = trial - {1'b0, radix_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      mag_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      mag_d = {mag_q[VALUE_WIDTH-2:0], ge};
      rem_d = ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
      cnt_d = cnt_q + BW'(1);
      if (cnt_q == BW'(VALUE_WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = mag_q;
  assign rem_o       = rem_q;

endmodule
`default_nettype wire

### sv/integer_to_radix_ascii_top.sv
// top level of the signed integer to radix ascii text formatter
// Usage:
//   value_i takes one signed integer request; the block works on one
//   request at a time and raises ready only when idle.
//   char_o gives the text one character per result: a leading '-' for a
//   negative value, then the digits most significant first, with last set
//   on the final character.
//   cfg_i writes the radix (2..36, values outside are saturated); it is
//   always ready and must only be written while the block is idle.
// Sequence:
//   for each digit the bit-serial divider shifts through the whole value,
//   then the remainder is stored in the digit store and the divider
//   restarts on the quotient.
//   The sign state follows, then each digit is read from the digit store
//   and loaded into the output register once that register is free.
// Reset: the radix returns to 10, the block goes idle, no result is valid.
// Stall: the output register holds its character until it is taken; the
//   next request can be accepted while the final character still waits.
`default_nettype none
module integer_to_radix_ascii_top import ira_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned DIGIT_DEPTH = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ira_value_if.sink   value_i,
  ira_char_if.source  char_o,
  ira_cfg_if.sink     cfg_i
);

  localparam int unsigned AW = $clog2(DIGIT_DEPTH);
  localparam int unsigned CW = $clog2(DIGIT_DEPTH + 1);

  ira_state_e             state_q, state_d;
  logic [RADIX_W-1:0]     radix_q, radix_d;
  logic [RADIX_W-1:0]     rsat_q, rsat_d;
  logic                   neg_q, neg_d;
  logic [CW-1:0]          count_q, count_d;
  logic                   out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]      out_char_q, out_char_d;
  logic                   out_last_q, out_last_d;

  logic                   in_acc;
  logic                   out_free;
  logic [VALUE_WIDTH-1:0] vbits;
  logic [VALUE_WIDTH-1:0] abs_val;
  logic [CW-1:0]          cnt_p1;
  logic [CW-1:0]          cnt_m1;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  div_stat_t              div_stat;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [RADIX_W-1:0]     div_rem;

  logic                   ram_we;
  logic                   ram_re;
  logic [RADIX_W-1:0]     ram_rdata;

  assign vbits    = value_i.value;
  assign abs_val  = vbits[VALUE_WIDTH-1] ? (~vbits + VALUE_WIDTH'(1)) : vbits;
  assign in_acc   = value_i.valid && value_i.ready;
  assign out_free = !out_valid_q || char_o.ready;
  assign cnt_p1   = count_q + CW'(1);
  assign cnt_m1   = count_q - CW'(1);

  assign value_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready   = 1'b1;

  assign char_o.valid     = out_valid_q;
  assign char_o.char_code = out_char_q;
  assign char_o.last      = out_last_q;

  always_comb begin
    state_d      = state_q;
    radix_d      = radix_q;
    rsat_d       = rsat_q;
    neg_d        = neg_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && !char_o.ready;
    out_char_d   = out_char_q;
    out_last_d   = out_last_q;
    div_start    = 1'b0;
    div_dividend = div_quot;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    if (cfg_i.valid) radix_d = cfg_i.data;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d      = ST_DIV;
          neg_d        = vbits[VALUE_WIDTH-1];
          rsat_d       = sat_radix(radix_q);
          count_d      = '0;
          div_start    = 1'b1;
          div_dividend = abs_val;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          ram_we  = 1'b1;
          count_d = cnt_p1;
          if ((div_quot == '0) || (cnt_p1 == CW'(DIGIT_DEPTH))) begin
            state_d = ST_SIGN;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ST_SIGN: begin
        if (!neg_q) begin
          state_d = ST_READ;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_MINUS;
          out_last_d  = 1'b0;
          state_d     = ST_READ;
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = digit_char(ram_rdata);
          out_last_d  = (count_q == CW'(1));
          count_d     = cnt_m1;
          state_d     = (count_q == CW'(1)) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radix_q     <= RADIX_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      radix_q     <= radix_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsat_q     <= rsat_d;
    neg_q      <= neg_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  ira_div #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .radix_i    (rsat_q),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  ira_ram #(
    .WIDTH (RADIX_W),
    .DEPTH (DIGIT_DEPTH)
  ) u_digit_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (div_rem),
    .re_i    (ram_re),
    .raddr_i (cnt_m1[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  a_accept_starts_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_DIV))
    else $error("request accepted without entering division");

  a_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_stat.busy || div_stat.done) |-> (state_q == ST_DIV))
    else $error("divider active outside division phase");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DIGIT_DEPTH))
    else $error("digit count beyond store depth");

  a_read_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_READ) || (state_q == ST_LOAD)) |-> (count_q != '0))
    else $error("digit read with empty store");

  a_last_to_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_LOAD) && out_free && (count_q == CW'(1)))
      |=> ((state_q == ST_IDLE) && out_last_q && out_valid_q))
    else $error("final character not flagged or block not idle");

endmodule
`default_nettype wire
